// File: rtl/artm_pkg.sv
package artm_pkg;

    localparam int MAX_REGIONS = 512;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int S_TDATA_W   = 3 * ADDR_W;
    localparam int M_TDATA_W   = 8;
    localparam int STATUS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_QUERY   = 2'd3
    } t_status;

    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_QUERY    = 1'b1;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [ADDR_W-1:0] wstart;
        logic [ADDR_W-1:0] wend;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic [ADDR_W-1:0] rstart;
        logic [ADDR_W-1:0] rend;
    } t_mem_rsp;

endpackage

// File: rtl/address_region_table_match_top.sv
// Address region table: a beat with tuser 0 appends the region
// [base, base + size) to a 512-entry table (a zero base or size is ignored,
// a full table drops the region), a beat with tuser 1 asks whether an address
// lies in any stored region. Every input beat yields exactly one result beat.
// A query walks the stored entries in order and stops at the first hit or
// after the last stored entry; the table sits in one memory with a single
// read port that is walked one entry per cycle. A new beat is taken while the
// previous result still waits in the output register.
module address_region_table_match_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [63:0] region_base, [127:64] region_size, [191:128] query_address
    input  logic [artm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] action
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] inside_res, [7:1] zero
    output logic [artm_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [1:0] status
    output logic [artm_pkg::STATUS_W-1:0]  o_m_tuser
);
    import artm_pkg::*;

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    artm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_mem_req  (mem_req),
        .i_mem_rsp  (mem_rsp)
    );

    artm_region_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule

// File: rtl/artm_region_mem.sv
module artm_region_mem (
    input  logic              i_clk,
    input  artm_pkg::t_mem_req i_req,
    output artm_pkg::t_mem_rsp o_rsp
);
    import artm_pkg::*;

    logic [ADDR_W-1:0] start_mem [MAX_REGIONS];
    logic [ADDR_W-1:0] end_mem   [MAX_REGIONS];
    logic [ADDR_W-1:0] r_rstart;
    logic [ADDR_W-1:0] r_rend;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            start_mem[i_req.waddr] <= i_req.wstart;
            end_mem[i_req.waddr]   <= i_req.wend;
        end
        if (i_req.re) begin
            r_rstart <= start_mem[i_req.raddr];
            r_rend   <= end_mem[i_req.raddr];
        end
    end

    assign o_rsp.rstart = r_rstart;
    assign o_rsp.rend   = r_rend;

endmodule

// File: rtl/artm_ctrl.sv
module artm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [artm_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [artm_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [artm_pkg::STATUS_W-1:0]  o_m_tuser,
    output artm_pkg::t_mem_req             o_mem_req,
    input  artm_pkg::t_mem_rsp             i_mem_rsp
);
    import artm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_out_vld, n_out_vld;
    logic [ADDR_W-1:0] r_addr, n_addr;
    t_status           r_pend_status, n_pend_status;
    logic              r_pend_hit, n_pend_hit;
    t_status           r_out_status, n_out_status;
    logic              r_out_hit, n_out_hit;

    logic [ADDR_W-1:0] in_base;
    logic [ADDR_W-1:0] in_size;
    logic [ADDR_W-1:0] in_addr;
    logic              in_beat;
    logic              full;
    logic              rd_en;
    logic              hit;
    logic              out_free;

    assign in_base  = i_s_tdata[ADDR_W-1:0];
    assign in_size  = i_s_tdata[2*ADDR_W-1:ADDR_W];
    assign in_addr  = i_s_tdata[3*ADDR_W-1:2*ADDR_W];
    assign in_beat  = i_s_tvalid && o_s_tready;
    assign full     = (r_count == CNT_W'(MAX_REGIONS));
    assign rd_en    = (r_state == S_SCAN) && (r_issue < r_count);
    assign hit      = r_cmp_vld && (r_addr >= i_mem_rsp.rstart) && (r_addr < i_mem_rsp.rend);
    assign out_free = !r_out_vld || i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_issue       = r_issue;
        n_cmp_vld     = 1'b0;
        n_addr        = r_addr;
        n_pend_status = r_pend_status;
        n_pend_hit    = r_pend_hit;
        n_out_vld     = r_out_vld && !i_m_tready;
        n_out_status  = r_out_status;
        n_out_hit     = r_out_hit;

        o_mem_req.we     = 1'b0;
        o_mem_req.waddr  = r_count[IDX_W-1:0];
        o_mem_req.wstart = in_base;
        o_mem_req.wend   = in_base + in_size;
        o_mem_req.re     = rd_en;
        o_mem_req.raddr  = r_issue[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_s_tuser == ACT_QUERY) begin
                        n_addr  = in_addr;
                        n_issue = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_pend_hit = 1'b0;
                        n_state    = S_RESULT;
                        if (in_base == '0 || in_size == '0) begin
                            n_pend_status = ST_IGNORED;
                        end else if (full) begin
                            n_pend_status = ST_FULL;
                        end else begin
                            n_pend_status = ST_STORED;
                            o_mem_req.we  = 1'b1;
                            n_count       = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = rd_en;
                if (rd_en) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                if (hit || !rd_en) begin
                    n_pend_status = ST_QUERY;
                    n_pend_hit    = hit;
                    n_cmp_vld     = 1'b0;
                    n_state       = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_hit    = r_pend_hit;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue       <= n_issue;
        r_addr        <= n_addr;
        r_pend_status <= n_pend_status;
        r_pend_hit    <= n_pend_hit;
        r_out_status  <= n_out_status;
        r_out_hit     <= n_out_hit;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_hit};

endmodule

// File: rtl/artm_checker.sv
module artm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [artm_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [artm_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [artm_pkg::STATUS_W-1:0]  o_m_tuser
);
    import artm_pkg::*;

    logic [1:0] r_pending, n_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_s_tvalid && o_s_tready;
    assign out_beat = o_m_tvalid && i_m_tready;

    always_comb begin
        n_pending = r_pending + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_hit_only_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_QUERY) |-> (o_m_tdata == '0))
        else $error("hit flag set on a register result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> (r_pending != 2'd0))
        else $error("result beat without an accepted item");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items outstanding");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd2) |-> !o_s_tready)
        else $error("input accepted with result path full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind address_region_table_match_top artm_checker u_artm_checker (.*);
